FILE: hdl/pee_pkg.sv
package pee_pkg;

  // Kind of work the back end carries out for one queued character.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_DIGIT = 3'd1,
    OP_ADD   = 3'd2,
    OP_SUB   = 3'd3,
    OP_MUL   = 3'd4,
    OP_DIV   = 3'd5
  } op_t;

  typedef struct packed {
    op_t        kind;
    logic [3:0] digit;
    logic       last;
  } item_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  localparam int QUEUE_DEPTH = 4;

endpackage

FILE: hdl/pee_ram.sv
module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/pee_front.sv
module pee_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // character
  input  logic              s_tlast,   // final_char
  input  logic              q_full,
  output logic              q_push,
  output pee_pkg::item_t    q_item
);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  logic [7:0] digit_full;

  assign digit_full = s_tdata - CH_ZERO;

  always_comb begin
    q_item.digit = digit_full[3:0];
    q_item.last  = s_tlast;
    priority if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE) begin
      q_item.kind = pee_pkg::OP_DIGIT;
    end else if (s_tdata == CH_PLUS) begin
      q_item.kind = pee_pkg::OP_ADD;
    end else if (s_tdata == CH_MINUS) begin
      q_item.kind = pee_pkg::OP_SUB;
    end else if (s_tdata == CH_STAR) begin
      q_item.kind = pee_pkg::OP_MUL;
    end else if (s_tdata == CH_SLASH) begin
      q_item.kind = pee_pkg::OP_DIV;
    end else begin
      q_item.kind = pee_pkg::OP_NONE;
    end
  end

  assign s_tready = !q_full;

  // Ignored characters only matter when they close the expression.
  assign q_push = s_tvalid && s_tready &&
                  (q_item.kind != pee_pkg::OP_NONE || s_tlast);

endmodule

FILE: hdl/pee_fifo.sv
module pee_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pee_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output pee_pkg::item_t head_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pee_pkg::item_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;

  assign full       = (fill == CW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

FILE: hdl/pee_div.sv
module pee_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [5:0]  step;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign shifted  = {rem, quo[31]};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = neg ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      // Restoring step: keep the difference when it did not go negative.
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == 6'd31);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 6'd1;
        if (step == 6'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

  start_while_idle : assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

endmodule

FILE: hdl/pee_back.sv
module pee_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  pee_pkg::item_t q_item,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [31:0]    m_tdata,   // value
  output logic [1:0]     m_tuser    // status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [1:0]      err, err_next;
  logic [31:0]     tos, tos_next;
  pee_pkg::op_t    kind, kind_next;
  logic            last, last_next;

  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   cnt_m2;
  logic            ram_we;
  logic [31:0]     left;
  logic            div_start;
  logic            div_done;
  logic [31:0]     div_q;
  logic            out_load;
  logic [1:0]      out_status;

  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);

  // The top of the stack lives in tos; the RAM holds the entries below it.
  pee_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_m1[AW-1:0]),
    .wdata(tos),
    .raddr(cnt_m2[AW-1:0]),
    .rdata(left)
  );

  pee_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(left),
    .divisor (tos),
    .done    (div_done),
    .quotient(div_q)
  );

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_load = (state == S_FIN) && (!m_tvalid || m_tready);

  always_comb begin
    if (err != pee_pkg::ST_OK) begin
      out_status = err;
    end else if (count == '0) begin
      out_status = pee_pkg::ST_UNDERFLOW;
    end else begin
      out_status = pee_pkg::ST_OK;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    err_next   = err;
    tos_next   = tos;
    kind_next  = kind;
    last_next  = last;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_pop) begin
          kind_next  = q_item.kind;
          last_next  = q_item.last;
          state_next = q_item.last ? S_FIN : S_IDLE;
          if (err == pee_pkg::ST_OK) begin
            unique case (q_item.kind)
              pee_pkg::OP_NONE: begin
              end
              pee_pkg::OP_DIGIT: begin
                if (count == CW'(STACK_DEPTH)) begin
                  err_next = pee_pkg::ST_OVERFLOW;
                end else begin
                  ram_we     = (count != '0);
                  tos_next   = {28'd0, q_item.digit};
                  count_next = count + CW'(1);
                end
              end
              pee_pkg::OP_ADD, pee_pkg::OP_SUB, pee_pkg::OP_MUL, pee_pkg::OP_DIV: begin
                if (count < CW'(2)) begin
                  err_next = pee_pkg::ST_UNDERFLOW;
                end else begin
                  state_next = S_EXEC;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_EXEC: begin
        state_next = last ? S_FIN : S_IDLE;
        count_next = cnt_m1;
        unique case (kind)
          pee_pkg::OP_ADD: tos_next = left + tos;
          pee_pkg::OP_SUB: tos_next = left - tos;
          pee_pkg::OP_MUL: tos_next = left * tos;
          pee_pkg::OP_DIV: begin
            if (tos == '0) begin
              err_next = pee_pkg::ST_DIVZERO;
              tos_next = '0;
            end else begin
              div_start  = 1'b1;
              count_next = count;
              state_next = S_DIV;
            end
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          tos_next   = div_q;
          count_next = cnt_m1;
          state_next = last ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (out_load) begin
          count_next = '0;
          err_next   = pee_pkg::ST_OK;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tos  <= tos_next;
    kind <= kind_next;
    last <= last_next;
    if (out_load) begin
      m_tdata <= (out_status == pee_pkg::ST_OK) ? tos : 32'd0;
      m_tuser <= out_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      err      <= pee_pkg::ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      err   <= err_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  count_in_range : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  result_from_finish : assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && (count == '0) && (err == pee_pkg::ST_OK))
    else $error("result load did not clear the expression state");

  divide_nonzero : assert property (@(posedge clk) disable iff (rst)
    div_start |-> (tos != '0) && (count >= CW'(2)))
    else $error("divider started without a valid nonzero divisor");

endmodule

FILE: hdl/postfix_expression_evaluator_top.sv
// Postfix expression evaluator: characters arrive one per transfer on the s_ side,
// digits push 0..9 onto a STACK_DEPTH-entry stack and + - * / combine the top two
// entries with 32-bit wrapping arithmetic (division truncates toward zero); other
// characters are ignored. The transfer with tlast set produces one result on the m_
// side: the top of the stack (zero unless ok) and a status (0 ok, 1 underflow,
// 2 overflow, 3 divide by zero), after which the stack is empty again. A four-entry
// queue separates character intake from execution. A digit is handled by the
// execution unit directly, an ignored character is not queued unless it closes the
// expression, + - * read the stack RAM and then execute, and / runs the 32-step
// restoring divider; the closing character then loads the result register. No
// clearing pass is needed after reset.
module postfix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] character
  input  logic        s_tlast,   // final_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic [1:0]  m_tuser    // [1:0] status
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  pee_pkg::item_t in_item;
  pee_pkg::item_t head_item;

  pee_front u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (in_item)
  );

  pee_fifo #(
    .DEPTH(pee_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (in_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_item (head_item)
  );

  pee_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (head_item),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
